/* design/dns_response_parser_macros.svh */
// ----------------------------------------------------------------------------
// DNS response parser assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef DNS_RESPONSE_PARSER_MACROS_SVH
`define DNS_RESPONSE_PARSER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DRP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define DRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/drp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drp_pkg
// Types and constants shared by the DNS response parser modules.
// ----------------------------------------------------------------------------
package drp_pkg;

	typedef logic [3:0] phase_t;

	localparam phase_t PH_HEADER = 4'd0;
	localparam phase_t PH_QNAME  = 4'd1;
	localparam phase_t PH_QPTR   = 4'd2;
	localparam phase_t PH_QFIXED = 4'd3;
	localparam phase_t PH_ANAME  = 4'd4;
	localparam phase_t PH_APTR   = 4'd5;
	localparam phase_t PH_AFIXED = 4'd6;
	localparam phase_t PH_RDATA  = 4'd7;
	localparam phase_t PH_RDNAME = 4'd8;
	localparam phase_t PH_DONE   = 4'd9;

	localparam logic [7:0]  DOT_CHAR    = 8'd46;
	localparam logic [7:0]  PTR_MASK    = 8'hC0;
	localparam logic [15:0] TYPE_A      = 16'h0001;
	localparam logic [15:0] TYPE_CNAME  = 16'h0005;
	localparam logic [15:0] CLASS_IN    = 16'h0001;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       alias_start;
		logic       address_start;
		logic [3:0] alias_count;
		logic [3:0] address_count;
	} res_t;

endpackage

/* design/drp_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drp_parser
// Message walk state and the per-byte next-state / result logic.
// ----------------------------------------------------------------------------
`include "dns_response_parser_macros.svh"

module drp_parser import drp_pkg::*; #(
	parameter int MAX_RECORDS = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step_en,
	input  logic [7:0] in_byte,
	input  logic       last,
	output res_t       res
);

	localparam logic [3:0] MAX_CNT = 4'(MAX_RECORDS);

	phase_t      phase_q,  phase_n;
	logic [3:0]  fpos_q,   fpos_n;   // saturates at 15, only small values matter
	logic [15:0] qtot_q,   qtot_n;
	logic [15:0] atot_q,   atot_n;
	logic [15:0] rtype_q,  rtype_n;
	logic [15:0] rclass_q, rclass_n;
	logic [15:0] dlen_q,   dlen_n;
	logic [7:0]  nla_q,    nla_n;
	logic [3:0]  names_q,  names_n;
	logic [3:0]  addrs_q,  addrs_n;

	logic        nm_end, nm_ptr, nm_label, alias_hit, addr_hit;
	logic [7:0]  nm_nla;
	logic [3:0]  fpos_inc;
	logic [15:0] dlen_dec;
	logic        as_bit, ad_bit;
	logic [7:0]  ob;
	phase_t      er_phase;
	logic [15:0] er_atot;

	always_comb begin
		// name byte classification
		nm_end    = (nla_q == 8'd0) && (in_byte == 8'd0);
		nm_ptr    = (nla_q == 8'd0) && ((in_byte & PTR_MASK) == PTR_MASK);
		nm_label  = (nla_q == 8'd0) && !nm_end && !nm_ptr;
		nm_nla    = (nla_q != 8'd0) ? nla_q - 8'd1 : (nm_label ? in_byte : 8'd0);
		alias_hit = (nla_q != 8'd0) && (fpos_q == 4'd1) && (names_q < MAX_CNT);
		addr_hit  = (fpos_q == 4'd0) && (rtype_q == TYPE_A) && (rclass_q == CLASS_IN)
			&& (addrs_q < MAX_CNT);
		fpos_inc  = (fpos_q == 4'hF) ? fpos_q : fpos_q + 4'd1;
		dlen_dec  = (dlen_q != 16'd0) ? dlen_q - 16'd1 : 16'd0;
		// end of an answer record
		if (atot_q <= 16'd1) begin
			er_phase = PH_DONE;
			er_atot  = 16'd0;
		end else begin
			er_phase = PH_ANAME;
			er_atot  = atot_q - 16'd1;
		end

		phase_n  = phase_q;
		fpos_n   = fpos_q;
		qtot_n   = qtot_q;
		atot_n   = atot_q;
		rtype_n  = rtype_q;
		rclass_n = rclass_q;
		dlen_n   = dlen_q;
		nla_n    = nla_q;
		ob       = in_byte;
		as_bit   = 1'b0;
		ad_bit   = 1'b0;

		case (phase_q)
			PH_HEADER: begin
				if (fpos_q == 4'd4 || fpos_q == 4'd5)
					qtot_n = {qtot_q[7:0], in_byte};
				else if (fpos_q == 4'd6 || fpos_q == 4'd7)
					atot_n = {atot_q[7:0], in_byte};
				if (fpos_q >= 4'd11) begin
					fpos_n = 4'd0;
					nla_n  = 8'd0;
					if (atot_q == 16'd0 || qtot_q > 16'd1)
						phase_n = PH_DONE;
					else if (qtot_q == 16'd1)
						phase_n = PH_QNAME;
					else
						phase_n = PH_ANAME;
				end else begin
					fpos_n = fpos_inc;
				end
			end
			PH_QNAME, PH_ANAME: begin
				fpos_n = fpos_inc;
				nla_n  = nm_nla;
				as_bit = alias_hit;
				if (nm_label)
					ob = DOT_CHAR;
				if (nm_end) begin
					phase_n = (phase_q == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
					fpos_n  = 4'd0;
					nla_n   = 8'd0;
				end else if (nm_ptr) begin
					phase_n = (phase_q == PH_QNAME) ? PH_QPTR : PH_APTR;
				end
			end
			PH_QPTR, PH_APTR: begin
				phase_n = (phase_q == PH_QPTR) ? PH_QFIXED : PH_AFIXED;
				fpos_n  = 4'd0;
				nla_n   = 8'd0;
			end
			PH_QFIXED: begin
				if (fpos_q >= 4'd3) begin
					phase_n = PH_ANAME;
					fpos_n  = 4'd0;
					nla_n   = 8'd0;
				end else begin
					fpos_n = fpos_inc;
				end
			end
			PH_AFIXED: begin
				if (fpos_q <= 4'd1)
					rtype_n = {rtype_q[7:0], in_byte};
				else if (fpos_q <= 4'd3)
					rclass_n = {rclass_q[7:0], in_byte};
				else if (fpos_q >= 4'd8)
					dlen_n = {dlen_q[7:0], in_byte};
				if (fpos_q >= 4'd9) begin
					fpos_n = 4'd0;
					nla_n  = 8'd0;
					if (dlen_n == 16'd0) begin
						phase_n = er_phase;
						atot_n  = er_atot;
					end else if (rtype_q == TYPE_CNAME && rclass_q == CLASS_IN)
						phase_n = PH_RDNAME;
					else
						phase_n = PH_RDATA;
				end else begin
					fpos_n = fpos_inc;
				end
			end
			PH_RDATA: begin
				ad_bit = addr_hit;
				fpos_n = fpos_inc;
				dlen_n = dlen_dec;
				if (dlen_dec == 16'd0) begin
					phase_n = er_phase;
					atot_n  = er_atot;
					fpos_n  = 4'd0;
					nla_n   = 8'd0;
				end
			end
			PH_RDNAME: begin
				fpos_n = fpos_inc;
				nla_n  = nm_nla;
				as_bit = alias_hit;
				dlen_n = dlen_dec;
				if (nm_label)
					ob = DOT_CHAR;
				// CNAME target stays inside its rdata
				if (dlen_dec == 16'd0) begin
					phase_n = er_phase;
					atot_n  = er_atot;
					fpos_n  = 4'd0;
					nla_n   = 8'd0;
				end else if (nm_end || nm_ptr) begin
					phase_n = PH_RDATA;
				end
			end
			default: ;
		endcase

		names_n = names_q + {3'd0, as_bit};
		addrs_n = addrs_q + {3'd0, ad_bit};

		res.out_byte      = ob;
		res.alias_start   = as_bit;
		res.address_start = ad_bit;
		res.alias_count   = names_n;
		res.address_count = addrs_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			fpos_q   <= 4'd0;
			qtot_q   <= 16'd0;
			atot_q   <= 16'd0;
			rtype_q  <= 16'd0;
			rclass_q <= 16'd0;
			dlen_q   <= 16'd0;
			nla_q    <= 8'd0;
			names_q  <= 4'd0;
			addrs_q  <= 4'd0;
		end else if (step_en) begin
			if (last) begin
				phase_q  <= PH_HEADER;
				fpos_q   <= 4'd0;
				qtot_q   <= 16'd0;
				atot_q   <= 16'd0;
				rtype_q  <= 16'd0;
				rclass_q <= 16'd0;
				dlen_q   <= 16'd0;
				nla_q    <= 8'd0;
				names_q  <= 4'd0;
				addrs_q  <= 4'd0;
			end else begin
				phase_q  <= phase_n;
				fpos_q   <= fpos_n;
				qtot_q   <= qtot_n;
				atot_q   <= atot_n;
				rtype_q  <= rtype_n;
				rclass_q <= rclass_n;
				dlen_q   <= dlen_n;
				nla_q    <= nla_n;
				names_q  <= names_n;
				addrs_q  <= addrs_n;
			end
		end
	end

	`DRP_ASSERT_NEXT(a_last_resets, clk, arst_n, step_en && last, phase_q == PH_HEADER && names_q == 4'd0 && addrs_q == 4'd0, "state not cleared after last byte")
	`DRP_ASSERT_NOW(a_label_in_name, clk, arst_n, nla_q != 8'd0, phase_q == PH_QNAME || phase_q == PH_ANAME || phase_q == PH_RDNAME, "label count left outside a name")
	`DRP_ASSERT_NEXT(a_done_sticks, clk, arst_n, step_en && !last && phase_q == PH_DONE, phase_q == PH_DONE, "parser left done before message end")

endmodule

/* design/dns_response_parser.sv */
`timescale 1ns / 1ps
// Path: a byte transferred in passes the input register, then the result register, to m_*.
// Throughput: one byte per cycle while m_tready stays high; input and result registers keep both sides moving.
// Backpressure: the input register holds while the result register is stalled.
// Reset: arst_n clears all valids and the parse state; the parser returns to the
// header phase, and it also does so after every byte carrying tlast.
// ----------------------------------------------------------------------------
// dns_response_parser
// Streaming DNS response walker: rewrites label lengths, marks alias and
// A-record address starts, and counts both per message.
// ----------------------------------------------------------------------------
`include "dns_response_parser_macros.svh"

module dns_response_parser import drp_pkg::*; #(
	parameter int MAX_RECORDS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	// receive side
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // last byte of message
	// result side
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [11:8] alias_count, [15:12] address_count
	output logic [1:0]  m_tuser,   // [0] alias_start, [1] address_start
	output logic        m_tlast    // end_of_message
);

	// stage 1: input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	// stage 2: result register
	logic       valid_s2;
	res_t       res_s2;
	logic       last_s2;

	logic adv_s2;   // result register can take a new value
	logic step_en;  // stage 1 byte moves into the parser this edge
	res_t res_c;

	assign adv_s2   = !valid_s2 || m_tready;
	assign step_en  = valid_s1 && adv_s2;
	assign s_tready = !valid_s1 || adv_s2;

	drp_parser #(
		.MAX_RECORDS(MAX_RECORDS)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step_en(step_en),
		.in_byte(byte_s1),
		.last   (last_s1),
		.res    (res_c)
	);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (step_en) begin
			res_s2  <= res_c;
			last_s2 <= last_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.address_count, res_s2.alias_count, res_s2.out_byte};
	assign m_tuser  = {res_s2.address_start, res_s2.alias_start};
	assign m_tlast  = last_s2;

	`DRP_ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !adv_s2, valid_s1 && $stable(byte_s1) && $stable(last_s1), "input register lost a byte under stall")
	`DRP_ASSERT_NEXT(a_step_fills_s2, clk, arst_n, step_en, valid_s2 && m_tlast == $past(last_s1), "parsed byte did not reach the result register")
	`DRP_ASSERT_NOW(a_counts_capped, clk, arst_n, valid_s2, res_s2.alias_count <= 4'(MAX_RECORDS) && res_s2.address_count <= 4'(MAX_RECORDS), "record count above limit")

endmodule

/* verif/dns_response_parser_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_response_parser_test
// Self-checking bench for the DNS response parser. Message bytes are built
// into a queue: two fixed messages, then random responses with random record
// mixes. Some are cut short and some are plain noise. A clocked driver feeds
// the bytes with random gaps. A byte-level model of the parse walk predicts
// every result transfer. A clocked monitor compares each result with the
// oldest prediction while the result side stalls at random.
// ----------------------------------------------------------------------------
module dns_response_parser_test import drp_pkg::*;;

	localparam int MAX_RECORDS = 10;
	localparam int TAIL_ITEMS  = 120;	// no idling once this few bytes remain

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} msg_byte_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       alias_start;
		logic       address_start;
		logic [3:0] alias_count;
		logic [3:0] address_count;
		logic       eom;
	} walk_result_t;

	typedef enum logic [1:0] {NAME_GOES_ON, NAME_ENDED, NAME_POINTER} name_ev_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	msg_byte_t    msg_bytes[$];	// bytes waiting to be sent
	logic [7:0]   frame[$];	// message under construction
	walk_result_t walk_q[$];	// predicted results, oldest first
	msg_byte_t    next_byte;
	walk_result_t got, want;
	int           send_gap;
	int           stall;
	int           mismatches = 0;

	// parse walk model state
	phase_t      w_phase;
	logic [15:0] w_pos;
	logic [15:0] w_qd;
	logic [15:0] w_an_left;
	logic [15:0] w_type;
	logic [15:0] w_class;
	logic [15:0] w_rd_left;
	logic [15:0] w_label_left;
	logic [3:0]  w_aliases;
	logic [3:0]  w_addresses;

	dns_response_parser #(
		.MAX_RECORDS(MAX_RECORDS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------- parse walk model ----------------

	function automatic void clear_walk();
		w_phase = PH_HEADER;
		w_pos = '0;
		w_qd = '0;
		w_an_left = '0;
		w_type = '0;
		w_class = '0;
		w_rd_left = '0;
		w_label_left = '0;
		w_aliases = '0;
		w_addresses = '0;
	endfunction

	function automatic void step_pos();
		if (w_pos != 16'hFFFF)
			w_pos++;
	endfunction

	function automatic void enter(input phase_t p);
		w_phase = p;
		w_pos = '0;
		w_label_left = '0;
	endfunction

	function automatic void close_record();
		if (w_an_left <= 16'd1) begin
			w_an_left = '0;
			enter(PH_DONE);
		end else begin
			w_an_left--;
			enter(PH_ANAME);
		end
	endfunction

	// one byte of a name; the first character of its first label may count as an alias
	function automatic name_ev_t name_step(input logic [7:0] b, inout walk_result_t r);
		name_ev_t ev;
		ev = NAME_GOES_ON;
		if (w_label_left != 0) begin
			w_label_left--;
			if (w_pos == 16'd1 && w_aliases < MAX_RECORDS) begin
				w_aliases++;
				r.alias_start = 1'b1;
			end
		end else if (b == 8'd0) begin
			ev = NAME_ENDED;
		end else if ((b & PTR_MASK) == PTR_MASK) begin
			ev = NAME_POINTER;
		end else begin
			r.out_byte = DOT_CHAR;
			w_label_left = {8'd0, b};
		end
		step_pos();
		return ev;
	endfunction

	function automatic walk_result_t predict_byte(input logic [7:0] b, input logic last);
		walk_result_t r;
		name_ev_t ev;
		r = '0;
		r.out_byte = b;
		case (w_phase)
			PH_HEADER: begin
				if (w_pos == 16'd4 || w_pos == 16'd5)
					w_qd = {w_qd[7:0], b};
				else if (w_pos == 16'd6 || w_pos == 16'd7)
					w_an_left = {w_an_left[7:0], b};
				if (w_pos >= 16'd11) begin
					if (w_an_left == 0 || w_qd > 16'd1)
						enter(PH_DONE);
					else if (w_qd == 16'd1)
						enter(PH_QNAME);
					else
						enter(PH_ANAME);
				end else begin
					step_pos();
				end
			end
			PH_QNAME: begin
				ev = name_step(b, r);
				if (ev == NAME_ENDED)
					enter(PH_QFIXED);
				else if (ev == NAME_POINTER)
					w_phase = PH_QPTR;
			end
			PH_QPTR: enter(PH_QFIXED);
			PH_QFIXED: begin
				if (w_pos >= 16'd3)
					enter(PH_ANAME);
				else
					step_pos();
			end
			PH_ANAME: begin
				ev = name_step(b, r);
				if (ev == NAME_ENDED)
					enter(PH_AFIXED);
				else if (ev == NAME_POINTER)
					w_phase = PH_APTR;
			end
			PH_APTR: enter(PH_AFIXED);
			PH_AFIXED: begin
				// type, class, ttl, rdlength
				if (w_pos <= 16'd1)
					w_type = {w_type[7:0], b};
				else if (w_pos <= 16'd3)
					w_class = {w_class[7:0], b};
				else if (w_pos >= 16'd8)
					w_rd_left = {w_rd_left[7:0], b};
				if (w_pos >= 16'd9) begin
					if (w_rd_left == 0)
						close_record();
					else if (w_type == TYPE_CNAME && w_class == CLASS_IN)
						enter(PH_RDNAME);
					else
						enter(PH_RDATA);
				end else begin
					step_pos();
				end
			end
			PH_RDATA: begin
				if (w_pos == 0 && w_type == TYPE_A && w_class == CLASS_IN
						&& w_addresses < MAX_RECORDS) begin
					w_addresses++;
					r.address_start = 1'b1;
				end
				step_pos();
				if (w_rd_left != 0)
					w_rd_left--;
				if (w_rd_left == 0)
					close_record();
			end
			PH_RDNAME: begin
				// CNAME target, bounded by rdlength
				ev = name_step(b, r);
				if (w_rd_left != 0)
					w_rd_left--;
				if (w_rd_left == 0)
					close_record();
				else if (ev != NAME_GOES_ON)
					w_phase = PH_RDATA;
			end
			default: ;
		endcase
		r.alias_count = w_aliases;
		r.address_count = w_addresses;
		r.eom = last;
		if (last)
			clear_walk();
		return r;
	endfunction

	// ---------------- message building ----------------

	task automatic put_u16(input logic [15:0] v);
		frame.push_back(v[15:8]);
		frame.push_back(v[7:0]);
	endtask

	// labels with random content, ended by a zero byte or a pointer
	task automatic put_name(input int max_labels, output int nbytes);
		int start, n, len;
		start = frame.size();
		n = $urandom_range(0, max_labels);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 39) == 0)
				len = ($urandom_range(0, 1) ? 64 : 128) + $urandom_range(0, 3);
			else if ($urandom_range(0, 9) == 0)
				len = $urandom_range(5, 63);
			else
				len = $urandom_range(1, 4);
			frame.push_back(len[7:0]);
			repeat (len) frame.push_back(8'($urandom));
		end
		if ($urandom_range(0, 3) == 0) begin
			frame.push_back(PTR_MASK | 8'($urandom_range(0, 63)));
			frame.push_back(8'($urandom));
		end else begin
			frame.push_back(8'd0);
		end
		nbytes = frame.size() - start;
	endtask

	// move the frame to the send queue, maybe cut short; tlast on its final byte
	task automatic send_frame(input bit may_cut);
		int len;
		len = frame.size();
		if (may_cut && $urandom_range(0, 9) == 0)
			len = $urandom_range(1, frame.size());
		for (int i = 0; i < len; i++)
			msg_bytes.push_back('{data: frame[i], last: (i == len - 1)});
		frame.delete();
	endtask

	// random response; "many" asks for enough records to saturate the counts
	task automatic build_message(input bit many);
		logic [15:0] qd, an, rdlen;
		int nb, kind, nlen, at, extra, pick, names;
		names = many ? 1 : 3;
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 30)) frame.push_back(8'($urandom));
			send_frame(0);
			return;
		end
		pick = $urandom_range(0, 9);
		qd = (pick == 0) ? 16'd0 : (pick == 1) ? 16'($urandom_range(2, 65535)) : 16'd1;
		pick = $urandom_range(0, 9);
		if (many)
			an = 16'($urandom_range(11, 13));
		else
			an = (pick == 0) ? 16'd0 : (pick == 1) ? 16'($urandom) : 16'($urandom_range(1, 4));
		nb = (an > 16'd13) ? $urandom_range(0, 4) : int'(an);
		put_u16(16'($urandom));
		put_u16(16'($urandom));
		put_u16(qd);
		put_u16(an);
		put_u16(16'($urandom));
		put_u16(16'($urandom));
		if (qd != 0) begin
			put_name(3, nlen);
			put_u16(($urandom_range(0, 3) == 0) ? 16'($urandom) : TYPE_A);
			put_u16(CLASS_IN);
		end
		for (int i = 0; i < nb; i++) begin
			kind = $urandom_range(0, 9);
			put_name(names, nlen);
			if (kind <= 5)
				put_u16(TYPE_A);
			else if (kind <= 8)
				put_u16(TYPE_CNAME);
			else
				put_u16(16'($urandom));
			put_u16(($urandom_range(0, 7) == 0) ? 16'($urandom) : CLASS_IN);
			put_u16(16'($urandom));
			put_u16(16'($urandom));
			pick = $urandom_range(0, 9);
			if (kind >= 6 && kind <= 8) begin
				// target length is known only after the name is built
				put_u16(16'd0);
				at = frame.size() - 2;
				put_name(names, nlen);
				if (pick == 0) begin
					rdlen = 16'($urandom_range(0, nlen));
				end else if (pick == 1) begin
					extra = $urandom_range(1, 3);
					rdlen = 16'(nlen + extra);
					repeat (extra) frame.push_back(8'($urandom));
				end else begin
					rdlen = 16'(nlen);
				end
				frame[at] = rdlen[15:8];
				frame[at + 1] = rdlen[7:0];
			end else begin
				if (kind <= 5)
					rdlen = (pick == 0) ? 16'd0 :
						(pick == 1) ? 16'($urandom_range(1, 8)) : 16'd4;
				else
					rdlen = (pick == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
				put_u16(rdlen);
				repeat ((rdlen > 16'd8) ? $urandom_range(0, 6) : int'(rdlen))
					frame.push_back(8'($urandom));
			end
		end
		repeat ($urandom_range(0, 3)) frame.push_back(8'($urandom));
		send_frame(1);
	endtask

	// ---------------- driver ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'd0;
			s_tlast <= 1'b0;
			send_gap = 0;
			clear_walk();
		end else begin
			if (s_tvalid && s_tready)
				walk_q.push_back(predict_byte(s_tdata, s_tlast));
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (msg_bytes.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (msg_bytes.size() >= TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
					send_gap = $urandom_range(0, 12);
					s_tvalid <= 1'b0;
				end else begin
					next_byte = msg_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_byte.data;
					s_tlast <= next_byte.last;
				end
			end
		end
	end

	// result side backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall = 0;
		end else if (stall > 0) begin
			stall--;
			m_tready <= 1'b0;
		end else if (msg_bytes.size() >= TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
			stall = $urandom_range(0, 12);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// ---------------- monitor ----------------

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got.out_byte = m_tdata[7:0];
			got.alias_count = m_tdata[11:8];
			got.address_count = m_tdata[15:12];
			got.alias_start = m_tuser[0];
			got.address_start = m_tuser[1];
			got.eom = m_tlast;
			if (walk_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result transfer with none expected: %p", $realtime, got);
			end else begin
				want = walk_q.pop_front();
				if (got.out_byte !== want.out_byte || got.alias_start !== want.alias_start
						|| got.address_start !== want.address_start
						|| got.alias_count !== want.alias_count
						|| got.address_count !== want.address_count
						|| got.eom !== want.eom) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch expected %p actual %p", $realtime, want, got);
				end
			end
		end
	end

	// ---------------- stimulus and end of run ----------------

	initial begin
		// all-ones and all-zeros header, no answers: parse stops, cut at byte 12
		for (int i = 0; i < 12; i++)
			frame.push_back((i >= 4 && i <= 7) ? 8'h00 : 8'hFF);
		send_frame(0);
		// no question, one IN A answer whose owner name is a pointer
		put_u16(16'h1234);
		put_u16(16'h8180);
		put_u16(16'd0);
		put_u16(16'd1);
		put_u16(16'd0);
		put_u16(16'd0);
		put_u16({PTR_MASK, 8'h0C});
		put_u16(TYPE_A);
		put_u16(CLASS_IN);
		put_u16(16'h0000);
		put_u16(16'h0E10);
		put_u16(16'd4);
		put_u16(16'hC0A8);
		put_u16(16'h0001);
		send_frame(0);
		// random part, starting with one message that saturates the counts
		build_message(1);
		while (msg_bytes.size() < 660)
			build_message($urandom_range(0, 7) == 0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		while (msg_bytes.size() != 0 || s_tvalid)
			@(posedge clk);
		while (walk_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
